@@ design/pgg_pkg.sv @@
// Types, codes and helpers shared by the periodic ghost particle generator.
`timescale 1ns / 1ps
package pgg_pkg;

  localparam int POS_W       = 32;
  localparam int WIDE_W      = 34;
  localparam int EXT_W       = 33;
  localparam int SUPPORT_W   = 31;
  localparam int IDX_W       = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_CAUSES  = 10;
  localparam int CAUSE_W     = 4;
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [EXT_W-1:0]  ext_t;
  typedef logic [NUM_CAUSES-1:0]    cause_mask_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOX_MIN_X      = 3'd0,
    REG_BOX_MIN_Y      = 3'd1,
    REG_BOX_MIN_Z      = 3'd2,
    REG_BOX_MAX_X      = 3'd3,
    REG_BOX_MAX_Y      = 3'd4,
    REG_BOX_MAX_Z      = 3'd5,
    REG_SUPPORT_RANGE  = 3'd6,
    REG_DIMENSION_MODE = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_1D = 2'd0,
    MODE_XZ = 2'd1,
    MODE_3D = 2'd2
  } mode_t;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_LEFT        = 4'd0,
    CAUSE_RIGHT       = 4'd1,
    CAUSE_FRONT       = 4'd2,
    CAUSE_BACK        = 4'd3,
    CAUSE_BOTTOM      = 4'd4,
    CAUSE_TOP         = 4'd5,
    CAUSE_TOPRIGHT    = 4'd6,
    CAUSE_TOPLEFT     = 4'd7,
    CAUSE_BOTTOMLEFT  = 4'd8,
    CAUSE_BOTTOMRIGHT = 4'd9
  } cause_t;

  localparam pos_t  RESET_MIN       = 32'sd0;
  localparam pos_t  RESET_MAX       = 32'sd65536;
  localparam logic [SUPPORT_W-1:0] RESET_SUPPORT = 31'd6554;
  localparam wide_t RESET_LOW_BAND  = 34'sd6554;
  localparam wide_t RESET_HIGH_BAND = 34'sd58982;
  localparam ext_t  RESET_EXTENT    = 33'sd65536;

  typedef struct packed {
    pos_t  min;
    pos_t  max;
    wide_t low_band;
    wide_t high_band;
    ext_t  extent;
  } axis_bounds_t;

  typedef struct packed {
    axis_bounds_t x;
    axis_bounds_t y;
    axis_bounds_t z;
    logic         use_y;
    logic         use_z;
    logic         corners;
  } bounds_t;

  typedef struct packed {
    pos_t             pos_x;
    pos_t             pos_y;
    pos_t             pos_z;
    logic [IDX_W-1:0] particle_index;
  } in_beat_t;

  typedef struct packed {
    pos_t               ghost_x;
    pos_t               ghost_y;
    pos_t               ghost_z;
    logic [IDX_W-1:0]   source_index;
    logic [CAUSE_W-1:0] mirror_cause;
    logic               is_last;
  } out_beat_t;

  typedef struct packed {
    pos_t             pos_x;
    pos_t             pos_y;
    pos_t             pos_z;
    logic [IDX_W-1:0] index;
    cause_mask_t      mask;
  } entry_t;

  function automatic wide_t widen(pos_t p);
    return {{(WIDE_W-POS_W){p[POS_W-1]}}, p};
  endfunction

  function automatic pos_t sat32(wide_t v);
    pos_t r;
    if (v > widen(32'sh7FFF_FFFF)) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < widen(32'sh8000_0000)) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ design/pgg_stream_if.sv @@
// Valid/ready stream channel carrying one payload beat.
`timescale 1ns / 1ps
interface pgg_stream_if #(parameter type payload_t = logic [0:0]) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/pgg_config.sv @@
// Configuration registers and derived band limits and box extents.
`timescale 1ns / 1ps
module pgg_config (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pgg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgg_pkg::CFG_DATA_W-1:0] cfg_data,
  output pgg_pkg::bounds_t               bounds
);
  import pgg_pkg::*;

  pos_t                 min_x, min_y, min_z;
  pos_t                 max_x, max_y, max_z;
  logic [SUPPORT_W-1:0] support;
  logic [1:0]           mode;
  pos_t                 min_x_next, min_y_next, min_z_next;
  pos_t                 max_x_next, max_y_next, max_z_next;
  logic [SUPPORT_W-1:0] support_next;
  logic [1:0]           mode_next;
  wide_t                sr_next;

  assign sr_next = {{(WIDE_W-SUPPORT_W){1'b0}}, support_next};

  always_comb begin
    min_x_next   = min_x;
    min_y_next   = min_y;
    min_z_next   = min_z;
    max_x_next   = max_x;
    max_y_next   = max_y;
    max_z_next   = max_z;
    support_next = support;
    mode_next    = mode;
    if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_BOX_MIN_X:      min_x_next   = cfg_data;
        REG_BOX_MIN_Y:      min_y_next   = cfg_data;
        REG_BOX_MIN_Z:      min_z_next   = cfg_data;
        REG_BOX_MAX_X:      max_x_next   = cfg_data;
        REG_BOX_MAX_Y:      max_y_next   = cfg_data;
        REG_BOX_MAX_Z:      max_z_next   = cfg_data;
        REG_SUPPORT_RANGE:  support_next = cfg_data[SUPPORT_W-1:0];
        REG_DIMENSION_MODE: mode_next    = cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x   <= RESET_MIN;
      min_y   <= RESET_MIN;
      min_z   <= RESET_MIN;
      max_x   <= RESET_MAX;
      max_y   <= RESET_MAX;
      max_z   <= RESET_MAX;
      support <= RESET_SUPPORT;
      mode    <= MODE_3D;
    end else begin
      min_x   <= min_x_next;
      min_y   <= min_y_next;
      min_z   <= min_z_next;
      max_x   <= max_x_next;
      max_y   <= max_y_next;
      max_z   <= max_z_next;
      support <= support_next;
      mode    <= mode_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds.x       <= '{RESET_MIN, RESET_MAX, RESET_LOW_BAND, RESET_HIGH_BAND, RESET_EXTENT};
      bounds.y       <= '{RESET_MIN, RESET_MAX, RESET_LOW_BAND, RESET_HIGH_BAND, RESET_EXTENT};
      bounds.z       <= '{RESET_MIN, RESET_MAX, RESET_LOW_BAND, RESET_HIGH_BAND, RESET_EXTENT};
      bounds.use_y   <= 1'b1;
      bounds.use_z   <= 1'b1;
      bounds.corners <= 1'b0;
    end else begin
      bounds.x <= '{min_x_next, max_x_next, widen(min_x_next) + sr_next,
                    widen(max_x_next) - sr_next,
                    ext_t'({max_x_next[POS_W-1], max_x_next} -
                           {min_x_next[POS_W-1], min_x_next})};
      bounds.y <= '{min_y_next, max_y_next, widen(min_y_next) + sr_next,
                    widen(max_y_next) - sr_next,
                    ext_t'({max_y_next[POS_W-1], max_y_next} -
                           {min_y_next[POS_W-1], min_y_next})};
      bounds.z <= '{min_z_next, max_z_next, widen(min_z_next) + sr_next,
                    widen(max_z_next) - sr_next,
                    ext_t'({max_z_next[POS_W-1], max_z_next} -
                           {min_z_next[POS_W-1], min_z_next})};
      unique case (mode_next)
        MODE_XZ: begin
          bounds.use_y   <= 1'b0;
          bounds.use_z   <= 1'b1;
          bounds.corners <= 1'b1;
        end
        MODE_3D: begin
          bounds.use_y   <= 1'b1;
          bounds.use_z   <= 1'b1;
          bounds.corners <= 1'b0;
        end
        default: begin
          bounds.use_y   <= 1'b0;
          bounds.use_z   <= 1'b0;
          bounds.corners <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ design/pgg_front.sv @@
// Front end: accept particles, classify them against the face bands, push work.
`timescale 1ns / 1ps
module pgg_front #(
  parameter int INDEX_BITS = 16
) (
  pgg_stream_if.sink         particle,
  input  pgg_pkg::bounds_t   bounds,
  input  logic               queue_full,
  output logic               push,
  output pgg_pkg::entry_t    push_entry
);
  import pgg_pkg::*;

  localparam int KEEP_BITS = (INDEX_BITS < IDX_W) ? INDEX_BITS : IDX_W;
  localparam logic [IDX_W-1:0] KEEP_MASK = IDX_W'((64'd1 << KEEP_BITS) - 64'd1);

  function automatic logic near_low(pos_t p, axis_bounds_t a);
    return (widen(p) < a.low_band) && (p > a.min);
  endfunction

  function automatic logic near_high(pos_t p, axis_bounds_t a);
    return (widen(p) > a.high_band) && (p < a.max);
  endfunction

  logic        xl, xh, yl, yh, zl, zh;
  cause_mask_t mask;

  always_comb begin
    xl = near_low(particle.data.pos_x, bounds.x);
    xh = near_high(particle.data.pos_x, bounds.x);
    yl = near_low(particle.data.pos_y, bounds.y);
    yh = near_high(particle.data.pos_y, bounds.y);
    zl = near_low(particle.data.pos_z, bounds.z);
    zh = near_high(particle.data.pos_z, bounds.z);
    mask                    = '0;
    mask[CAUSE_LEFT]        = xl;
    mask[CAUSE_RIGHT]       = xh;
    mask[CAUSE_FRONT]       = bounds.use_y & yl;
    mask[CAUSE_BACK]        = bounds.use_y & yh;
    mask[CAUSE_BOTTOM]      = bounds.use_z & zl;
    mask[CAUSE_TOP]         = bounds.use_z & zh;
    mask[CAUSE_TOPRIGHT]    = bounds.corners & zh & xh;
    mask[CAUSE_TOPLEFT]     = bounds.corners & zh & xl;
    mask[CAUSE_BOTTOMLEFT]  = bounds.corners & zl & xl;
    mask[CAUSE_BOTTOMRIGHT] = bounds.corners & zl & xh;
  end

  assign particle.ready   = !queue_full;
  assign push             = particle.valid && !queue_full && (mask != '0);
  assign push_entry.pos_x = particle.data.pos_x;
  assign push_entry.pos_y = particle.data.pos_y;
  assign push_entry.pos_z = particle.data.pos_z;
  assign push_entry.index = particle.data.particle_index & KEEP_MASK;
  assign push_entry.mask  = mask;

endmodule

@@ design/pgg_queue.sv @@
// Short work queue between the classifier and the ghost emitter.
`timescale 1ns / 1ps
module pgg_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pgg_pkg::entry_t push_entry,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output pgg_pkg::entry_t head
);
  import pgg_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'((wr_ptr + 1'b1) % QUEUE_DEPTH);
      end
      if (pop) begin
        rd_ptr <= PTR_W'((rd_ptr + 1'b1) % QUEUE_DEPTH);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) !head_valid |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) head_valid |-> head.mask != '0)
    else $error("queued entry without ghosts");

endmodule

@@ design/pgg_back.sv @@
// Back end: walk each entry's cause mask and emit one saturated ghost per beat.
`timescale 1ns / 1ps
module pgg_back (
  input  logic              clk,
  input  logic              rst,
  input  pgg_pkg::bounds_t  bounds,
  input  logic              head_valid,
  input  pgg_pkg::entry_t   head,
  output logic              pop,
  pgg_stream_if.source      ghost
);
  import pgg_pkg::*;

  entry_t             cur;
  logic               cur_valid;
  cause_mask_t        pick, rest;
  logic [CAUSE_W-1:0] pick_code;
  logic               last, adv;
  logic               x_plus, x_minus, y_plus, y_minus, z_plus, z_minus;
  out_beat_t          beat_next;

  function automatic pos_t shift(pos_t p, ext_t e, logic plus, logic minus);
    wide_t s;
    wide_t d;
    s = widen(p);
    d = {e[EXT_W-1], e};
    if (plus) begin
      s = s + d;
    end else if (minus) begin
      s = s - d;
    end
    return sat32(s);
  endfunction

  always_comb begin
    pick      = cur.mask & (~cur.mask + 1'b1);
    rest      = cur.mask & ~pick;
    last      = (rest == '0);
    pick_code = '0;
    for (int i = 0; i < NUM_CAUSES; i++) begin
      if (pick[i]) begin
        pick_code = CAUSE_W'(i);
      end
    end
    x_plus  = pick[CAUSE_LEFT] | pick[CAUSE_TOPLEFT] | pick[CAUSE_BOTTOMLEFT];
    x_minus = pick[CAUSE_RIGHT] | pick[CAUSE_TOPRIGHT] | pick[CAUSE_BOTTOMRIGHT];
    y_plus  = pick[CAUSE_FRONT];
    y_minus = pick[CAUSE_BACK];
    z_plus  = pick[CAUSE_BOTTOM] | pick[CAUSE_BOTTOMLEFT] | pick[CAUSE_BOTTOMRIGHT];
    z_minus = pick[CAUSE_TOP] | pick[CAUSE_TOPRIGHT] | pick[CAUSE_TOPLEFT];
    beat_next.ghost_x      = shift(cur.pos_x, bounds.x.extent, x_plus, x_minus);
    beat_next.ghost_y      = shift(cur.pos_y, bounds.y.extent, y_plus, y_minus);
    beat_next.ghost_z      = shift(cur.pos_z, bounds.z.extent, z_plus, z_minus);
    beat_next.source_index = cur.index;
    beat_next.mirror_cause = pick_code;
    beat_next.is_last      = last;
  end

  assign adv = cur_valid && (!ghost.valid || ghost.ready);
  assign pop = head_valid && (!cur_valid || (adv && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (adv && last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (adv) begin
      cur.mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ghost.valid <= 1'b0;
    end else if (adv) begin
      ghost.valid <= 1'b1;
    end else if (ghost.ready) begin
      ghost.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ghost.data <= beat_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cur_valid |-> $onehot(pick))
    else $error("active entry has no pending ghost");
  assert property (@(posedge clk) disable iff (rst) (adv && !last) |=> cur_valid)
    else $error("entry dropped before its last ghost");
  assert property (@(posedge clk) disable iff (rst)
                   (cur_valid && !adv) |=> (cur_valid && $stable(cur.mask)))
    else $error("stalled entry changed");

endmodule

@@ design/periodic_ghost_particle_generator_unit.sv @@
// Top level of the periodic ghost particle generator.
// A particle's first ghost passes the queue, the entry register and the output register.
// Throughput: one particle accepted per cycle while the 4-entry work queue has room;
// the emitter sends one ghost per cycle unless the output stalls, one beat per ghost.
// Particles that make no ghost are dropped at the front and never enter the queue.
// Reset: synchronous; clears queue and output; registers return to their reset values.
`timescale 1ns / 1ps
module periodic_ghost_particle_generator_unit #(
  parameter int INDEX_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pgg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgg_pkg::CFG_DATA_W-1:0] cfg_data,
  pgg_stream_if.sink                     particle,
  pgg_stream_if.source                   ghost
);
  import pgg_pkg::*;

  bounds_t bounds;
  logic    queue_full, push, pop, head_valid;
  entry_t  push_entry, head;

  pgg_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .bounds    (bounds)
  );

  pgg_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .particle   (particle),
    .bounds     (bounds),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  pgg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  pgg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .bounds     (bounds),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .ghost      (ghost)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the periodic ghost particle generator unit.
`timescale 1ns / 1ps
module testbench;
  import pgg_pkg::*;

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pgg_stream_if #(.payload_t(in_beat_t)) particle_ch ();
  pgg_stream_if #(.payload_t(out_beat_t)) ghost_ch ();

  periodic_ghost_particle_generator_unit #(.INDEX_BITS(IDX_W)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .particle(particle_ch),
    .ghost(ghost_ch)
  );

  pos_t box_lo [3] = '{RESET_MIN, RESET_MIN, RESET_MIN};
  pos_t box_hi [3] = '{RESET_MAX, RESET_MAX, RESET_MAX};
  logic [SUPPORT_W-1:0] band_width = RESET_SUPPORT;
  logic [1:0] mode_bits = MODE_3D;

  out_beat_t expected_ghosts [$];
  out_beat_t want_ghost;

  int error_count = 0;
  int particles_sent = 0;
  int ghosts_checked = 0;
  int settings_loaded = 0;
  int cause_hits [NUM_CAUSES];

  bit in_burst = 0;
  bit tx_steady = 0;
  bit rx_free = 0;
  int burst_left = 0;
  int rx_count = 0;
  int rx_on = 0;
  int rx_off = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic pos_t clip32(longint v);
    pos_t r;
    if (v > POS_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < POS_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic out_beat_t make_ghost(longint gx, longint gy, longint gz,
                                           logic [IDX_W-1:0] idx, cause_t cause);
    out_beat_t g;
    g.ghost_x = clip32(gx);
    g.ghost_y = clip32(gy);
    g.ghost_z = clip32(gz);
    g.source_index = idx;
    g.mirror_cause = cause;
    g.is_last = 1'b0;
    return g;
  endfunction

  function automatic void predict_ghosts(in_beat_t b);
    longint p [3];
    longint lo [3];
    longint hi [3];
    longint ext [3];
    longint sr;
    bit near_lo [3];
    bit near_hi [3];
    bit use_y;
    bit use_z;
    bit corners;
    logic [IDX_W-1:0] idx;
    out_beat_t made [$];
    p[0] = longint'($signed(b.pos_x));
    p[1] = longint'($signed(b.pos_y));
    p[2] = longint'($signed(b.pos_z));
    idx = b.particle_index;
    sr = longint'(band_width);
    for (int a = 0; a < 3; a++) begin
      lo[a] = longint'(box_lo[a]);
      hi[a] = longint'(box_hi[a]);
      ext[a] = hi[a] - lo[a];
      near_lo[a] = p[a] > lo[a] && p[a] < lo[a] + sr;
      near_hi[a] = p[a] < hi[a] && p[a] > hi[a] - sr;
    end
    use_y = mode_bits == MODE_3D;
    use_z = mode_bits == MODE_XZ || mode_bits == MODE_3D;
    corners = mode_bits == MODE_XZ;
    if (near_lo[0]) made = {made, make_ghost(p[0] + ext[0], p[1], p[2], idx, CAUSE_LEFT)};
    if (near_hi[0]) made = {made, make_ghost(p[0] - ext[0], p[1], p[2], idx, CAUSE_RIGHT)};
    if (use_y && near_lo[1])
      made = {made, make_ghost(p[0], p[1] + ext[1], p[2], idx, CAUSE_FRONT)};
    if (use_y && near_hi[1])
      made = {made, make_ghost(p[0], p[1] - ext[1], p[2], idx, CAUSE_BACK)};
    if (use_z && near_lo[2])
      made = {made, make_ghost(p[0], p[1], p[2] + ext[2], idx, CAUSE_BOTTOM)};
    if (use_z && near_hi[2])
      made = {made, make_ghost(p[0], p[1], p[2] - ext[2], idx, CAUSE_TOP)};
    if (corners) begin
      if (near_hi[2] && near_hi[0])
        made = {made, make_ghost(p[0] - ext[0], p[1], p[2] - ext[2], idx, CAUSE_TOPRIGHT)};
      if (near_hi[2] && near_lo[0])
        made = {made, make_ghost(p[0] + ext[0], p[1], p[2] - ext[2], idx, CAUSE_TOPLEFT)};
      if (near_lo[2] && near_lo[0])
        made = {made, make_ghost(p[0] + ext[0], p[1], p[2] + ext[2], idx, CAUSE_BOTTOMLEFT)};
      if (near_lo[2] && near_hi[0])
        made = {made, make_ghost(p[0] - ext[0], p[1], p[2] + ext[2], idx, CAUSE_BOTTOMRIGHT)};
    end
    if (made.size() > 0) made[made.size()-1].is_last = 1'b1;
    expected_ghosts = {expected_ghosts, made};
  endfunction

  function automatic pos_t rand_pos();
    pos_t r;
    r = $urandom;
    return r;
  endfunction

  function automatic pos_t pick_coord(int a);
    longint lo;
    longint hi;
    longint sr;
    longint off;
    longint v;
    lo = longint'(box_lo[a]);
    hi = longint'(box_hi[a]);
    sr = longint'(band_width);
    off = longint'($urandom_range(0, 32'(sr + 2)));
    case ($urandom_range(0, 11))
      0, 1, 2, 3: v = lo + off - 1;
      4, 5, 6, 7: v = hi - off + 1;
      8: begin
        case ($urandom_range(0, 5))
          0: v = lo;
          1: v = lo + sr;
          2: v = hi;
          3: v = hi - sr;
          4: v = lo + 1;
          default: v = hi - 1;
        endcase
      end
      9: v = longint'(rand_pos());
      10: v = (hi > lo) ? lo + longint'($urandom) % (hi - lo + 1) : lo;
      default: begin
        case ($urandom_range(0, 3))
          0: v = POS_MIN;
          1: v = POS_MAX;
          2: v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return clip32(v);
  endfunction

  always @(posedge clk) begin
    if (rx_free) begin
      ghost_ch.ready <= 1'b1;
    end else begin
      if (rx_count == 0) begin
        rx_on = $urandom_range(1, 6);
        rx_off = $urandom_range(0, 4);
        rx_count = rx_on + rx_off;
      end
      ghost_ch.ready <= (rx_count > rx_off);
      rx_count--;
    end
  end

  always @(posedge clk) begin
    if (!rst && ghost_ch.valid && ghost_ch.ready) begin
      if (expected_ghosts.size() == 0) begin
        $error("ghost beat with nothing expected: cause %0d index %0d",
               ghost_ch.data.mirror_cause, ghost_ch.data.source_index);
        error_count++;
      end else begin
        want_ghost = expected_ghosts.pop_front();
        ghosts_checked++;
        cause_hits[want_ghost.mirror_cause]++;
        if (ghost_ch.data.ghost_x !== want_ghost.ghost_x) begin
          $error("ghost_x: expected %0d, got %0d",
                 $signed(want_ghost.ghost_x), $signed(ghost_ch.data.ghost_x));
          error_count++;
        end
        if (ghost_ch.data.ghost_y !== want_ghost.ghost_y) begin
          $error("ghost_y: expected %0d, got %0d",
                 $signed(want_ghost.ghost_y), $signed(ghost_ch.data.ghost_y));
          error_count++;
        end
        if (ghost_ch.data.ghost_z !== want_ghost.ghost_z) begin
          $error("ghost_z: expected %0d, got %0d",
                 $signed(want_ghost.ghost_z), $signed(ghost_ch.data.ghost_z));
          error_count++;
        end
        if (ghost_ch.data.source_index !== want_ghost.source_index) begin
          $error("source_index: expected %0d, got %0d",
                 want_ghost.source_index, ghost_ch.data.source_index);
          error_count++;
        end
        if (ghost_ch.data.mirror_cause !== want_ghost.mirror_cause) begin
          $error("mirror_cause: expected %0d, got %0d",
                 want_ghost.mirror_cause, ghost_ch.data.mirror_cause);
          error_count++;
        end
        if (ghost_ch.data.is_last !== want_ghost.is_last) begin
          $error("is_last: expected %0d, got %0d",
                 want_ghost.is_last, ghost_ch.data.is_last);
          error_count++;
        end
      end
    end
  end

  task automatic send_particle(pos_t x, pos_t y, pos_t z, logic [IDX_W-1:0] idx);
    in_beat_t b;
    int gap;
    b.pos_x = x;
    b.pos_y = y;
    b.pos_z = z;
    b.particle_index = idx;
    particle_ch.valid <= 1'b1;
    particle_ch.data <= b;
    in_burst = 1;
    @(posedge clk);
    while (!particle_ch.ready) @(posedge clk);
    predict_ghosts(b);
    particles_sent++;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 10);
        particle_ch.valid <= 1'b0;
        in_burst = 0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic settle();
    if (in_burst) begin
      particle_ch.valid <= 1'b0;
      in_burst = 0;
    end
    while (expected_ghosts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_setting(pos_t lx, pos_t ly, pos_t lz, pos_t hx, pos_t hy, pos_t hz,
                              logic [SUPPORT_W-1:0] sr, logic [1:0] md);
    logic [CFG_DATA_W-1:0] word [8];
    reg_index_t r;
    settle();
    word[REG_BOX_MIN_X] = lx;
    word[REG_BOX_MIN_Y] = ly;
    word[REG_BOX_MIN_Z] = lz;
    word[REG_BOX_MAX_X] = hx;
    word[REG_BOX_MAX_Y] = hy;
    word[REG_BOX_MAX_Z] = hz;
    word[REG_SUPPORT_RANGE] = {1'($urandom), sr};
    word[REG_DIMENSION_MODE] = {30'($urandom), md};
    r = REG_BOX_MIN_X;
    repeat (8) begin
      cfg_we <= 1'b1;
      cfg_index <= r;
      cfg_data <= word[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
    box_lo[0] = lx;
    box_lo[1] = ly;
    box_lo[2] = lz;
    box_hi[0] = hx;
    box_hi[1] = hy;
    box_hi[2] = hz;
    band_width = sr;
    mode_bits = md;
    settings_loaded++;
  endtask

  task automatic load_random_setting();
    longint lo [3];
    longint hi [3];
    logic [SUPPORT_W-1:0] sr;
    int kind;
    kind = $urandom_range(0, 5);
    for (int a = 0; a < 3; a++) begin
      case (kind)
        0, 1, 2: begin
          lo[a] = longint'($urandom_range(0, 2097152)) - 1048576;
          hi[a] = lo[a] + longint'($urandom_range(4096, 1048576));
        end
        3: begin
          lo[a] = longint'(rand_pos());
          hi[a] = longint'(rand_pos());
        end
        4: begin
          hi[a] = longint'($urandom_range(0, 2097152)) - 1048576;
          lo[a] = hi[a] + longint'($urandom_range(4096, 1048576));
        end
        default: begin
          lo[a] = POS_MIN;
          hi[a] = POS_MAX;
        end
      endcase
    end
    case (kind)
      0, 1, 2, 4: sr = 31'($urandom_range(1, 262144));
      3: sr = 31'($urandom);
      default: sr = ($urandom_range(0, 1) == 1) ? 31'h7FFF_FFFF : 31'($urandom);
    endcase
    load_setting(clip32(lo[0]), clip32(lo[1]), clip32(lo[2]),
                 clip32(hi[0]), clip32(hi[1]), clip32(hi[2]), sr, 2'($urandom_range(0, 3)));
  endtask

  task automatic test_reset_defaults();
    send_particle(32'sd32768, 32'sd32768, 32'sd32768, 16'd0);
    send_particle(32'sd1, 32'sd32768, 32'sd32768, 16'd1);
    send_particle(32'sd65535, 32'sd32768, 32'sd32768, 16'd2);
    send_particle(32'sd100, 32'sd100, 32'sd100, 16'd3);
    send_particle(32'sd65500, 32'sd65500, 32'sd65500, 16'hFFFF);
    send_particle(32'sd0, 32'sd6554, 32'sd65536, 16'd5);
    send_particle(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd58982, 16'd6);
  endtask

  task automatic test_one_dim();
    load_setting(32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 32'sd65536, 31'd6554, MODE_1D);
    send_particle(32'sd100, 32'sd100, 32'sd100, 16'd10);
    send_particle(32'sd65500, 32'sd65500, 32'sd65500, 16'd11);
    load_setting(32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 32'sd65536, 31'd6554, 2'd3);
    send_particle(32'sd100, 32'sd100, 32'sd100, 16'd12);
    send_particle(32'sd65500, 32'sd65500, 32'sd65500, 16'd13);
  endtask

  task automatic test_xz_corners();
    load_setting(32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 32'sd65536, 31'd6554, MODE_XZ);
    send_particle(32'sd100, 32'sd100, 32'sd100, 16'd20);
    send_particle(32'sd65500, 32'sd65500, 32'sd65500, 16'd21);
    send_particle(32'sd100, 32'sd32768, 32'sd65500, 16'd22);
    send_particle(32'sd65500, 32'sd32768, 32'sd100, 16'd23);
  endtask

  task automatic test_inverted_box();
    load_setting(32'sd65536, 32'sd65536, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 31'd6554, MODE_3D);
    send_particle(32'sd66000, 32'sd32768, 32'sd66000, 16'd30);
    send_particle(-32'sd100, -32'sd100, 32'sd32768, 16'd31);
  endtask

  task automatic test_saturation();
    load_setting(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, MODE_XZ);
    send_particle(-32'sd5, 32'sd7, 32'sd5, 16'd40);
    send_particle(32'sh8000_0001, 32'sd0, 32'sh7FFF_FFFE, 16'd41);
    send_particle(32'sd0, 32'sd0, 32'sh8000_0000, 16'd42);
  endtask

  task automatic test_zero_support();
    load_setting(32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd65536, 32'sd65536, 31'd0, MODE_XZ);
    send_particle(32'sd1, 32'sd1, 32'sd1, 16'd50);
    send_particle(32'sd65535, 32'sd65535, 32'sd65535, 16'd51);
  endtask

  task automatic test_random_particles();
    for (int seg = 0; seg < 9; seg++) begin
      tx_steady = (seg % 3 == 2);
      rx_free = (seg % 4 == 1);
      load_random_setting();
      repeat (30) send_particle(pick_coord(0), pick_coord(1), pick_coord(2), 16'($urandom));
    end
    tx_steady = 0;
    rx_free = 0;
  endtask

  initial begin
    string hits;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_BOX_MIN_X;
    cfg_data = '0;
    particle_ch.valid = 1'b0;
    particle_ch.data = '0;
    ghost_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_one_dim();
    test_xz_corners();
    test_inverted_box();
    test_saturation();
    test_zero_support();
    test_random_particles();
    settle();

    hits = "";
    foreach (cause_hits[i]) hits = {hits, $sformatf(" %0d", cause_hits[i])};
    $display("summary: %0d particles, %0d ghost beats checked, %0d register settings",
             particles_sent, ghosts_checked, settings_loaded);
    $display("summary: ghosts per cause, left to bottomright:%s", hits);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/pgg_pkg.sv
design/pgg_stream_if.sv
design/pgg_config.sv
design/pgg_front.sv
design/pgg_queue.sv
design/pgg_back.sv
design/periodic_ghost_particle_generator_unit.sv
tb/testbench.sv
